// ===== rtl/core/bblru_pkg.sv =====
`default_nettype none
package bblru_pkg;

    typedef enum logic [1:0] {
        ACT_GET      = 2'd0,
        ACT_CONTAINS = 2'd1,
        ACT_ADD      = 2'd2,
        ACT_SET_DISP = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MISS     = 3'd1,
        ST_DISABLED = 3'd2,
        ST_PRESENT  = 3'd3,
        ST_EVICTED  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK_RD,
        S_LOOK,
        S_DECIDE,
        S_VIC_RD,
        S_VIC,
        S_EVICT,
        S_INSERT,
        S_HIT
    } state_t;

    localparam int KEY_W   = 32;
    localparam int DIM_W   = 14;
    localparam int BYTES_W = 31;
    localparam int STAMP_W = 32;
    localparam int MIB_SHIFT = 20;

endpackage
`default_nettype wire

// ===== rtl/core/byte_budget_lru_cache_directory_top.sv =====
`default_nettype none
// image cache directory with a byte budget and lru eviction
// channels: a command word (action, key, width, height, displayed) is taken
// when start is high and busy is low; each result word shows for one cycle
// with strobe high, last marks the final word of a command
// config: budget_we writes budget_wdata (MiB) at any edge; zero disables
// timing: a command reads every slot of the entry memory once per pass,
// one slot per cycle; a hit or an add without eviction shows its word
// after that pass, a miss from the decide state ahead of the hit state,
// a disabled answer on the next cycle; each eviction adds a pass over all
// slots; a new command can be taken in the cycle of the final word
// busy is high from acceptance to the last word, not for a disabled answer
// reset clears valid and displayed marks, byte and entry counts and the
// use counter; entry memory contents need no clearing
// the receiver cannot stall; words are never held back
module byte_budget_lru_cache_directory_top #(
    parameter int ENTRIES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        budget_we,
    input  wire logic [9:0]  budget_wdata,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] key,
    input  wire logic [13:0] width,
    input  wire logic [13:0] height,
    input  wire logic        displayed,
    output logic             strobe,
    output logic [2:0]       status,
    output logic [3:0]       slot,
    output logic [31:0]      entry_key,
    output logic [13:0]      entry_width,
    output logic [13:0]      entry_height,
    output logic [30:0]      bytes_in_use,
    output logic [4:0]       entry_total,
    output logic             last
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int MW = bblru_pkg::KEY_W + 2 * bblru_pkg::DIM_W
                      + bblru_pkg::BYTES_W + bblru_pkg::STAMP_W;

    // entry memory: key, width, height, bytes, stamp
    logic [MW-1:0] mem [ENTRIES];
    logic [MW-1:0] rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [MW-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    logic [31:0] rd_key;
    logic [13:0] rd_w, rd_h;
    logic [30:0] rd_bytes;
    logic [31:0] rd_stamp;
    assign {rd_key, rd_w, rd_h, rd_bytes, rd_stamp} = rd_data_reg;

    // control registers
    bblru_pkg::state_t state_reg, state_next;
    logic [9:0]   budget_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next, disp_reg, disp_next;
    logic [30:0]  held_reg, held_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0]  ctr_reg, ctr_next;
    logic [1:0]   act_reg, act_next;
    logic [31:0]  key_reg, key_next;
    logic [13:0]  w_reg, w_next, h_reg, h_next;
    logic         dsp_reg, dsp_next;
    logic [IW:0]  idx_reg, idx_next;       // scan address, one wider
    logic [IW-1:0] pidx_reg, pidx_next;    // slot of data now in rd_data_reg
    logic         found_reg, found_next;
    logic [IW-1:0] fslot_reg, fslot_next;
    logic         vfound_reg, vfound_next;
    logic [IW-1:0] vslot_reg, vslot_next;
    logic [31:0]  vstamp_reg, vstamp_next;
    logic         vskip_reg, vskip_next;   // skip displayed entries
    logic [29:0]  size_reg, size_next;

    // output word registers
    logic         strobe_reg, strobe_next;
    logic [2:0]   status_reg, status_next;
    logic [IW-1:0] oslot_reg, oslot_next;
    logic [31:0]  okey_reg, okey_next;
    logic [13:0]  ow_reg, ow_next, oh_reg, oh_next;
    logic         last_reg, last_next;

    logic [30:0]  budget_bytes;
    logic [31:0]  need;
    logic         pinned_only;
    logic [IW-1:0] free_slot;
    logic         rd_valid;
    logic         rd_cand;

    assign budget_bytes = {1'b0, budget_reg, 20'd0};
    assign need = {1'b0, held_reg} + {2'b00, size_reg};
    assign rd_valid = valid_reg[pidx_reg];
    assign rd_cand  = rd_valid && !(vskip_reg && disp_reg[pidx_reg]);
    assign pinned_only = ((valid_reg & ~disp_reg) == '0);

    // lowest free slot
    always_comb
    begin
        free_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot = IW'(i);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bblru_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = (budget_reg == '0) ? bblru_pkg::S_IDLE
                                                     : bblru_pkg::S_LOOK_RD;
                end
            end
            bblru_pkg::S_LOOK_RD: state_next = bblru_pkg::S_LOOK;
            bblru_pkg::S_LOOK:
            begin
                if (idx_reg == (IW+1)'(ENTRIES))
                begin
                    state_next = bblru_pkg::S_DECIDE;
                end
            end
            bblru_pkg::S_DECIDE:
            begin
                if (found_reg)
                begin
                    state_next = bblru_pkg::S_HIT;
                end
                else if (act_reg != bblru_pkg::ACT_ADD)
                begin
                    state_next = bblru_pkg::S_IDLE;
                end
                else if (cnt_reg != '0 && (need > {1'b0, budget_bytes}
                         || cnt_reg == CW'(ENTRIES)))
                begin
                    state_next = bblru_pkg::S_VIC_RD;
                end
                else
                begin
                    state_next = bblru_pkg::S_INSERT;
                end
            end
            bblru_pkg::S_VIC_RD: state_next = bblru_pkg::S_VIC;
            bblru_pkg::S_VIC:
            begin
                if (idx_reg == (IW+1)'(ENTRIES))
                begin
                    state_next = bblru_pkg::S_EVICT;
                end
            end
            bblru_pkg::S_EVICT: state_next = bblru_pkg::S_DECIDE;
            bblru_pkg::S_INSERT: state_next = bblru_pkg::S_IDLE;
            bblru_pkg::S_HIT: state_next = bblru_pkg::S_IDLE;
            default: state_next = bblru_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        valid_next = valid_reg;
        disp_next = disp_reg;
        held_next = held_reg;
        cnt_next = cnt_reg;
        ctr_next = ctr_reg;
        act_next = act_reg;
        key_next = key_reg;
        w_next = w_reg;
        h_next = h_reg;
        dsp_next = dsp_reg;
        idx_next = idx_reg;
        pidx_next = idx_reg[IW-1:0];
        found_next = found_reg;
        fslot_next = fslot_reg;
        vfound_next = vfound_reg;
        vslot_next = vslot_reg;
        vstamp_next = vstamp_reg;
        vskip_next = vskip_reg;
        size_next = size_reg;
        strobe_next = 1'b0;
        status_next = status_reg;
        oslot_next = oslot_reg;
        okey_next = okey_reg;
        ow_next = ow_reg;
        oh_next = oh_reg;
        last_next = last_reg;
        rd_addr = idx_reg[IW-1:0];
        wr_en = 1'b0;
        wr_addr = pidx_reg;
        wr_data = rd_data_reg;
        case (state_reg)
            bblru_pkg::S_IDLE:
            begin
                if (start)
                begin
                    act_next = action;
                    key_next = key;
                    w_next = width;
                    h_next = height;
                    dsp_next = displayed;
                    idx_next = '0;
                    found_next = 1'b0;
                    if (budget_reg == '0)
                    begin
                        strobe_next = 1'b1;
                        status_next = bblru_pkg::ST_DISABLED;
                        oslot_next = '0;
                        okey_next = key;
                        ow_next = '0;
                        oh_next = '0;
                        last_next = 1'b1;
                    end
                end
            end
            bblru_pkg::S_LOOK_RD:
            begin
                size_next = 30'(w_reg * h_reg) << 2;
                idx_next = idx_reg + 1'b1;
            end
            bblru_pkg::S_LOOK:
            begin
                if (!found_reg && rd_valid && rd_key == key_reg)
                begin
                    found_next = 1'b1;
                    fslot_next = pidx_reg;
                end
                if (idx_reg != (IW+1)'(ENTRIES))
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    rd_addr = found_next ? fslot_next : pidx_reg;
                end
                if (idx_reg == (IW+1)'(ENTRIES))
                begin
                    rd_addr = found_next ? fslot_next : pidx_reg;
                end
            end
            bblru_pkg::S_DECIDE:
            begin
                rd_addr = fslot_reg;
                idx_next = '0;
                vfound_next = 1'b0;
                vskip_next = !pinned_only;
                if (!found_reg && act_reg != bblru_pkg::ACT_ADD)
                begin
                    strobe_next = 1'b1;
                    status_next = bblru_pkg::ST_MISS;
                    oslot_next = '0;
                    okey_next = key_reg;
                    ow_next = '0;
                    oh_next = '0;
                    last_next = 1'b1;
                end
            end
            bblru_pkg::S_HIT:
            begin
                // rd_data_reg holds the found slot
                strobe_next = 1'b1;
                oslot_next = fslot_reg;
                okey_next = rd_key;
                ow_next = rd_w;
                oh_next = rd_h;
                last_next = 1'b1;
                if (act_reg == bblru_pkg::ACT_ADD)
                begin
                    status_next = bblru_pkg::ST_PRESENT;
                end
                else
                begin
                    status_next = bblru_pkg::ST_OK;
                    if (act_reg == bblru_pkg::ACT_GET)
                    begin
                        wr_en = 1'b1;
                        wr_addr = fslot_reg;
                        wr_data = {rd_key, rd_w, rd_h, rd_bytes, ctr_reg};
                        ctr_next = ctr_reg + 1'b1;
                    end
                    else if (act_reg == bblru_pkg::ACT_SET_DISP)
                    begin
                        disp_next[fslot_reg] = dsp_reg;
                    end
                end
            end
            bblru_pkg::S_VIC_RD:
            begin
                idx_next = idx_reg + 1'b1;
            end
            bblru_pkg::S_VIC:
            begin
                if (rd_cand && (!vfound_reg || rd_stamp < vstamp_reg))
                begin
                    vfound_next = 1'b1;
                    vslot_next = pidx_reg;
                    vstamp_next = rd_stamp;
                end
                if (idx_reg != (IW+1)'(ENTRIES))
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    rd_addr = vfound_next ? vslot_next : pidx_reg;
                end
            end
            bblru_pkg::S_EVICT:
            begin
                // rd_data_reg holds the victim
                valid_next[vslot_reg] = 1'b0;
                disp_next[vslot_reg] = 1'b0;
                held_next = held_reg - rd_bytes;
                cnt_next = cnt_reg - 1'b1;
                strobe_next = 1'b1;
                status_next = bblru_pkg::ST_EVICTED;
                oslot_next = vslot_reg;
                okey_next = rd_key;
                ow_next = rd_w;
                oh_next = rd_h;
                last_next = 1'b0;
            end
            bblru_pkg::S_INSERT:
            begin
                valid_next[free_slot] = 1'b1;
                disp_next[free_slot] = 1'b0;
                wr_en = 1'b1;
                wr_addr = free_slot;
                wr_data = {key_reg, w_reg, h_reg, 1'b0, size_reg, ctr_reg};
                ctr_next = ctr_reg + 1'b1;
                held_next = need[30:0];
                cnt_next = cnt_reg + 1'b1;
                strobe_next = 1'b1;
                status_next = bblru_pkg::ST_OK;
                oslot_next = free_slot;
                okey_next = key_reg;
                ow_next = w_reg;
                oh_next = h_reg;
                last_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bblru_pkg::S_IDLE;
            budget_reg <= '0;
            valid_reg <= '0;
            disp_reg <= '0;
            held_reg <= '0;
            cnt_reg <= '0;
            ctr_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (budget_we)
            begin
                budget_reg <= budget_wdata;
            end
            valid_reg <= valid_next;
            disp_reg <= disp_next;
            held_reg <= held_next;
            cnt_reg <= cnt_next;
            ctr_reg <= ctr_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        key_reg <= key_next;
        w_reg <= w_next;
        h_reg <= h_next;
        dsp_reg <= dsp_next;
        idx_reg <= idx_next;
        pidx_reg <= pidx_next;
        found_reg <= found_next;
        fslot_reg <= fslot_next;
        vfound_reg <= vfound_next;
        vslot_reg <= vslot_next;
        vstamp_reg <= vstamp_next;
        vskip_reg <= vskip_next;
        size_reg <= size_next;
        status_reg <= status_next;
        oslot_reg <= oslot_next;
        okey_reg <= okey_next;
        ow_reg <= ow_next;
        oh_reg <= oh_next;
        last_reg <= last_next;
    end

    // ports
    assign busy = (state_reg != bblru_pkg::S_IDLE) || strobe_reg && !last_reg;
    assign strobe = strobe_reg;
    assign status = status_reg;
    assign slot = 4'(oslot_reg);
    assign entry_key = okey_reg;
    assign entry_width = ow_reg;
    assign entry_height = oh_reg;
    assign bytes_in_use = held_reg;
    assign entry_total = 5'(cnt_reg);
    assign last = last_reg;
endmodule
`default_nettype wire

// ===== rtl/core/bblru_checker.sv =====
`default_nettype none
// port level checks for the cache directory
module bblru_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        strobe,
    input wire logic [2:0]  status,
    input wire logic [4:0]  entry_total,
    input wire logic        last
);
    // an accepted command keeps busy high or answers at once
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || strobe)
        else $error("command accepted without activity");

    // eviction words are never final
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status == bblru_pkg::ST_EVICTED |-> !last)
        else $error("eviction marked last");

    // an eviction drops the entry count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status == bblru_pkg::ST_EVICTED |->
        entry_total == $past(entry_total) - 5'd1)
        else $error("eviction count mismatch");

    // no word without a command in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy) || $past(start))
        else $error("unsolicited word");
endmodule

bind byte_budget_lru_cache_directory_top bblru_checker u_bblru_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .strobe(strobe),
    .status(status), .entry_total(entry_total), .last(last)
);
`default_nettype wire
